FILE: rtl/core/abf_pkg.sv
// abf_pkg: shared types, constants and helpers for the allocation bitmap.
// Used by every module of the allocation_bitmap_first_free block.
// No dependencies.
package abf_pkg;

  // Map geometry
  localparam int         MAP_BITS_DEF = 4096;
  localparam int         WORD_BITS    = 8;
  localparam logic [7:0] FULL_WORD    = 8'd255;

  // Configuration register
  localparam int         CFG_W     = 10;
  localparam logic [9:0] CFG_RESET = 10'd512;

  // Operation codes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // Input item
  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] position;
    logic        flag;
  } in_t;

  // Result item
  typedef struct packed {
    logic        bit_value;
    logic [11:0] free_index;
    logic        found;
    logic        out_of_range;
  } out_t;

  // Lowest clear bit of a word (only meaningful when the word is not full)
  function automatic logic [2:0] first_zero(input logic [7:0] w);
    logic [2:0] idx;
    idx = 3'd0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (!w[j]) idx = 3'(j);
    end
    return idx;
  endfunction

endpackage

FILE: rtl/core/allocation_bitmap_first_free.sv
// allocation_bitmap_first_free: allocation bitmap with bit write/read and
// lowest-free-bit search. Top level; depends on abf_pkg, abf_seq, abf_map_mem.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one operation per
//   transfer: write a bit, read a bit, or search for the lowest free bit.
//   Each operation yields exactly one result transfer on the output channel
//   (out_valid/out_stall/out_data), in order.
//   cfg_we/cfg_wdata set the number of active map bytes; write it only while
//   no operation is in flight.
// Sequence:
//   Write/read: accept and issue the read, then read-modify-write, then hand-off.
//   Search: words are scanned from word 0 up to the first non-full one
//   (up to the active byte count); the map memory is read one word a cycle.
// Reset:
//   rst_n is synchronous, active low. After reset the map is cleared word by word
//   over all MAP_BITS/8 words (512 by default) with in_stall held high.
// Back-pressure:
//   The result sits in an output register while out_stall is high; the next
//   item may be accepted meanwhile but its result waits for the register.
module allocation_bitmap_first_free
  import abf_pkg::*;
#(
  parameter int MAP_BITS = MAP_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int NW   = MAP_BITS / WORD_BITS;
  localparam int AW   = (NW > 1) ? $clog2(NW) : 1;
  localparam int CNTW = $clog2(NW + 1);
  localparam int CMPW = (CNTW > CFG_W) ? CNTW : CFG_W;

  logic [CFG_W-1:0] bytes_in_use_r;
  logic [CMPW-1:0]  cfg_ext;
  logic [CMPW-1:0]  active_words;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       wr_data;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data;

  // Active byte count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_in_use_r <= CFG_RESET;
    end else if (cfg_we) begin
      bytes_in_use_r <= cfg_wdata;
    end
  end

  // Saturate to the map size
  assign cfg_ext      = CMPW'(bytes_in_use_r);
  assign active_words = (cfg_ext > CMPW'(NW)) ? CMPW'(NW) : cfg_ext;

  abf_seq #(
    .MAP_BITS (MAP_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .active_words (active_words),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data)
  );

  abf_map_mem #(
    .MAP_BITS (MAP_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

FILE: rtl/core/abf_map_mem.sv
// abf_map_mem: byte-wide bitmap storage, one write and one registered read port.
// Depends on abf_pkg.
module abf_map_mem
  import abf_pkg::*;
#(
  parameter int MAP_BITS = MAP_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((MAP_BITS/WORD_BITS) > 1 ? $clog2(MAP_BITS/WORD_BITS) : 1)-1:0] wr_addr,
  input  logic [7:0]                                   wr_data,
  input  logic [((MAP_BITS/WORD_BITS) > 1 ? $clog2(MAP_BITS/WORD_BITS) : 1)-1:0] rd_addr,
  output logic [7:0]                                   rd_data
);

  localparam int NW = MAP_BITS / WORD_BITS;

  logic [7:0] mem [NW];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/abf_seq.sv
// abf_seq: sequencer for clearing, bit write/read and the first-free scan,
// plus the result output register. Depends on abf_pkg; drives abf_map_mem.
module abf_seq
  import abf_pkg::*;
#(
  parameter int MAP_BITS = MAP_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic [((($clog2(MAP_BITS/WORD_BITS+1)) > CFG_W) ?
                 $clog2(MAP_BITS/WORD_BITS+1) : CFG_W)-1:0] active_words,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data,
  output logic wr_en,
  output logic [((MAP_BITS/WORD_BITS) > 1 ? $clog2(MAP_BITS/WORD_BITS) : 1)-1:0] wr_addr,
  output logic [7:0] wr_data,
  output logic [((MAP_BITS/WORD_BITS) > 1 ? $clog2(MAP_BITS/WORD_BITS) : 1)-1:0] rd_addr,
  input  logic [7:0] rd_data
);

  localparam int NW   = MAP_BITS / WORD_BITS;
  localparam int AW   = (NW > 1) ? $clog2(NW) : 1;
  localparam int CNTW = $clog2(NW + 1);
  localparam int CMPW = (CNTW > CFG_W) ? CNTW : CFG_W;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_ACCESS = 5'b00100,
    S_SCAN   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [1:0]      op_r, op_nxt;
  logic [2:0]      shift_r, shift_nxt;
  logic            flag_r, flag_nxt;
  logic            oor_r, oor_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [CMPW-1:0] scan_r, scan_nxt;
  out_t            res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_t            out_data_r, out_data_nxt;

  logic            in_accept;
  logic            out_free;
  logic [CMPW-1:0] word_idx;
  logic [CMPW-1:0] scan_inc;
  logic [7:0]      bit_mask;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign word_idx  = {{(CMPW-9){1'b0}}, in_data.position[11:3]};
  assign scan_inc  = scan_r + CMPW'(1);
  assign bit_mask  = 8'd1 << shift_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next-state and memory access control
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    shift_nxt     = shift_r;
    flag_nxt      = flag_r;
    oor_nxt       = oor_r;
    addr_nxt      = addr_r;
    scan_nxt      = scan_r;
    res_nxt       = res_r;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = addr_r;
    wr_data       = rd_data;

    unique case (state_r)
      // zero the map one word per cycle after reset
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(NW - 1)) state_nxt = S_IDLE;
      end
      // take an item and launch its first read
      S_IDLE: begin
        rd_addr = (in_data.opcode == OP_SEARCH) ? '0 : word_idx[AW-1:0];
        if (in_accept) begin
          op_nxt    = in_data.opcode;
          shift_nxt = in_data.position[2:0];
          flag_nxt  = in_data.flag;
          addr_nxt  = word_idx[AW-1:0];
          oor_nxt   = (word_idx >= active_words);
          scan_nxt  = '0;
          res_nxt   = '0;
          unique case (in_data.opcode)
            OP_WRITE, OP_READ: state_nxt = S_ACCESS;
            OP_SEARCH:         state_nxt = (active_words == '0) ? S_DONE : S_SCAN;
            default:           state_nxt = S_DONE;
          endcase
        end
      end
      // read data is back: flag out of range, or modify and write, or pick the bit
      S_ACCESS: begin
        if (oor_r) begin
          res_nxt.out_of_range = 1'b1;
        end else if (op_r == OP_WRITE) begin
          wr_en   = 1'b1;
          wr_data = flag_r ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
        end else begin
          res_nxt.bit_value = rd_data[shift_r];
        end
        state_nxt = S_DONE;
      end
      // one word per cycle, next read issued in parallel
      S_SCAN: begin
        rd_addr = scan_inc[AW-1:0];
        if (rd_data != FULL_WORD) begin
          res_nxt.found      = 1'b1;
          res_nxt.free_index = {scan_r[8:0], first_zero(rd_data)};
          state_nxt          = S_DONE;
        end else if (scan_inc >= active_words) begin
          state_nxt = S_DONE;
        end else begin
          scan_nxt = scan_inc;
        end
      end
      // hand the result to the output register
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if ((state_r == S_DONE) && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    shift_r    <= shift_nxt;
    flag_r     <= flag_nxt;
    oor_r      <= oor_nxt;
    addr_r     <= addr_nxt;
    scan_r     <= scan_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: rtl/core/abf_checker.sv
// abf_checker: port-level assertions for allocation_bitmap_first_free,
// attached by bind. Depends on abf_pkg.
module abf_checker
  import abf_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Input blocked while the map clears after reset
  a_clear_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open during map clear");

  // One item at a time: busy right after an input transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in flight");

  // Search hits carry no read bit and no range flag
  a_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> !out_data.bit_value && !out_data.out_of_range)
    else $error("search result mixed with read/range fields");

  // Index is zero unless a free bit was found
  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.free_index == 12'd0)
    else $error("free index set without found");

endmodule

bind allocation_bitmap_first_free abf_checker u_abf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
